### rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;

  localparam int unsigned MaxExponent = 16;
  localparam int unsigned ExpW = $clog2(MaxExponent + 1);

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpPow = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0] res_den;
    logic        bad_result;
    logic        exp_overflow;
  } rsp_t;

  // classified request handed from front to back
  typedef enum logic [1:0] {
    KindPass  = 2'd0,
    KindCross = 2'd1,
    KindPow   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  op;
    logic [63:0] an;
    logic [63:0] ad;
    logic [63:0] bn;
    logic [63:0] bd;
  } job_t;

endpackage
`default_nettype wire

### rtl/rational_arithmetic_unit.sv
// rational arithmetic unit
// request channel: req_valid_i / req_ready_o with req_i (operation and two
// fractions); response channel: rsp_valid_o / rsp_ready_i with rsp_o.
// a front stage classifies each request (pass-through for a bad operand or
// unused operation, cross product or power) into a two-entry queue; the back
// stage does the work one request at a time.
// a bad operand or unused operation goes straight to the response; add,
// subtract, multiply and divide form products, find their gcd by euclid
// steps on the shared bit-serial divider and divide both by it (skipped when
// the raw numerator or denominator is zero), then normalise.
// power: a reduction of the exponent, a check, up to 16 multiplications,
// then a reduction of the result.
// the back stage is ready again in the cycle after a response is taken.
// reset clears queue and sequencer; no request is lost afterwards.
// when the receiver stalls the response holds on rsp_o, the back stage
// waits and the queue keeps taking up to two further requests.
`default_nettype none
module rational_arithmetic_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire rau_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output rau_pkg::rsp_t      rsp_o
);

  logic          job_valid, job_ready;
  rau_pkg::job_t job;

  rau_front u_front (
    .clk_i, .rst_ni,
    .req_valid_i, .req_ready_o, .req_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  rau_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

  a_bad_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.bad_result == (rsp_o.res_den == '0))) else $error("bad flag");
  a_ovf_bad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.exp_overflow |-> rsp_o.bad_result) else $error("overflow flag");
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o)) else $error("response hold");

endmodule
`default_nettype wire

### rtl/rau_front.sv
`default_nettype none
module rau_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire rau_pkg::req_t  req_i,
  output logic                job_valid_o,
  input  wire logic           job_ready_i,
  output rau_pkg::job_t       job_o
);

  // two-entry queue between front and back
  rau_pkg::job_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push, pop;
  rau_pkg::job_t job_d;

  always_comb begin
    job_d.op = req_i.req_type;
    job_d.an = 64'(req_i.a_num);
    job_d.ad = 64'(req_i.a_den);
    job_d.bn = 64'(req_i.b_num);
    job_d.bd = 64'(req_i.b_den);
    if (req_i.a_den == '0 || req_i.b_den == '0) begin
      job_d.kind = rau_pkg::KindPass;
    end else if (req_i.req_type == rau_pkg::OpPow) begin
      job_d.kind = rau_pkg::KindPow;
    end else if (req_i.req_type == rau_pkg::OpAdd || req_i.req_type == rau_pkg::OpSub ||
                 req_i.req_type == rau_pkg::OpMul || req_i.req_type == rau_pkg::OpDiv) begin
      job_d.kind = rau_pkg::KindCross;
    end else begin
      job_d.kind = rau_pkg::KindPass;
    end
  end

  assign req_ready_o = (cnt_q != 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = mem_q[rp_q];
  assign push = req_valid_i && req_ready_o;
  assign pop  = job_valid_o && job_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
    end
  end

endmodule
`default_nettype wire

### rtl/rau_divider.sv
`default_nettype none
module rau_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quot_o,
  output logic [63:0]      rem_o
);

  // unsigned restoring division, one bit per cycle
  logic [63:0] q_q, r_q, d_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [64:0] trial;
  logic [64:0] shifted;

  assign shifted = {r_q, q_q[63]};
  assign trial   = shifted - {1'b0, d_q};
  assign quot_o  = q_q;
  assign rem_o   = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[64]) begin
        r_q <= trial[63:0];
        q_q <= {q_q[62:0], 1'b1};
      end else begin
        r_q <= shifted[63:0];
        q_q <= {q_q[62:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### rtl/rau_back.sv
`default_nettype none
module rau_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  output logic               job_ready_o,
  input  wire rau_pkg::job_t job_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output rau_pkg::rsp_t      rsp_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMul   = 4'd1;
  localparam logic [3:0] StComb  = 4'd2;
  localparam logic [3:0] StRedSt = 4'd3;
  localparam logic [3:0] StGcd   = 4'd4;
  localparam logic [3:0] StDivN  = 4'd5;
  localparam logic [3:0] StDivD  = 4'd6;
  localparam logic [3:0] StNorm  = 4'd7;
  localparam logic [3:0] StPowCk = 4'd8;
  localparam logic [3:0] StPowMl = 4'd9;
  localparam logic [3:0] StOut   = 4'd10;

  logic [3:0] st_q;
  rau_pkg::job_t job_q;
  logic        pow_phase_q;   // reducing exponent, not the final result
  logic [63:0] num_q, den_q, u_q, v_q, g_q, pn_q, pd_q, en_q;
  logic [63:0] p0_q, p1_q, p2_q;
  logic [rau_pkg::ExpW-1:0] k_q;
  logic        busy_div_q;

  logic        dv_start, dv_done;
  logic [63:0] dv_a, dv_b, dv_q, dv_r;

  rau_divider u_div (
    .clk_i, .rst_ni,
    .start_i   (dv_start),
    .dividend_i(dv_a),
    .divisor_i (dv_b),
    .done_o    (dv_done),
    .quot_o    (dv_q),
    .rem_o     (dv_r)
  );

  function automatic logic [63:0] mag(input logic [63:0] x);
    mag = x[63] ? (64'd0 - x) : x;
  endfunction

  // signed 32 by 32 product, full 64 bits
  function automatic logic [63:0] smul32(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    smul32 = p;
  endfunction

  // 64-bit value times signed 32-bit factor, wrapping, from two 32-bit products
  function automatic logic [63:0] mul_wrap(input logic [63:0] p, input logic [31:0] a);
    logic [63:0] lo;
    logic [31:0] hi;
    lo = {32'd0, p[31:0]} * {32'd0, a};
    hi = p[63:32] * a;
    mul_wrap = lo + {hi, 32'd0} - (a[31] ? {p[31:0], 32'd0} : 64'd0);
  endfunction

  // divider operands chosen by state
  always_comb begin
    unique case (st_q)
      StDivN:  begin dv_a = mag(num_q); dv_b = mag(g_q); end
      StDivD:  begin dv_a = mag(den_q); dv_b = mag(g_q); end
      default: begin dv_a = mag(u_q);   dv_b = mag(v_q); end
    endcase
  end

  assign dv_start    = !busy_div_q && (st_q == StGcd || st_q == StDivN || st_q == StDivD)
                       && !(st_q == StGcd && v_q == '0);
  assign job_ready_o = (st_q == StIdle);

  logic [63:0] qn_signed, qd_signed, mag_e;
  assign qn_signed = (num_q[63] != g_q[63]) ? (64'd0 - dv_q) : dv_q;
  assign qd_signed = (den_q[63] != g_q[63]) ? (64'd0 - dv_q) : dv_q;
  assign mag_e     = mag(en_q);

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) job_q <= job_i;
    unique case (st_q)
      StIdle: if (job_valid_i) begin
        if (job_i.kind == rau_pkg::KindPass) begin
          den_q <= '0;
          if (job_i.ad == '0) num_q <= job_i.an;
          else if (job_i.bd == '0) num_q <= job_i.bn;
          else num_q <= 64'd1;
        end else begin
          num_q <= job_i.bn;
          den_q <= job_i.bd;
        end
      end
      StMul: begin
        unique case (job_q.op)
          rau_pkg::OpMul: begin
            p0_q <= smul32(job_q.an[31:0], job_q.bn[31:0]);
            p2_q <= smul32(job_q.ad[31:0], job_q.bd[31:0]);
          end
          rau_pkg::OpDiv: begin
            p0_q <= smul32(job_q.an[31:0], job_q.bd[31:0]);
            p2_q <= smul32(job_q.ad[31:0], job_q.bn[31:0]);
          end
          default: begin
            p0_q <= smul32(job_q.an[31:0], job_q.bd[31:0]);
            p1_q <= smul32(job_q.ad[31:0], job_q.bn[31:0]);
            p2_q <= smul32(job_q.ad[31:0], job_q.bd[31:0]);
          end
        endcase
      end
      StComb: begin
        unique case (job_q.op)
          rau_pkg::OpAdd: num_q <= p0_q + p1_q;
          rau_pkg::OpSub: num_q <= p0_q - p1_q;
          default:        num_q <= p0_q;
        endcase
        den_q <= p2_q;
      end
      StRedSt: begin
        u_q <= num_q;
        v_q <= den_q;
      end
      StGcd: begin
        if (v_q == '0) g_q <= u_q;
        else if (dv_done) begin
          u_q <= v_q;
          v_q <= u_q[63] ? (64'd0 - dv_r) : dv_r;
        end
      end
      StDivN: if (dv_done) num_q <= qn_signed;
      StDivD: if (dv_done) den_q <= qd_signed;
      StNorm: begin
        logic [63:0] n, d;
        n = num_q;
        d = den_q;
        if (d[63]) begin n = 64'd0 - n; d = 64'd0 - d; end
        if (n == '0) d = 64'd1;
        if (d == '0) n = 64'd1;
        if (d == 64'h8000_0000_0000_0000) begin n = 64'd1; d = '0; end
        num_q <= n;
        den_q <= d;
        if (pow_phase_q) begin
          en_q <= n;
          pn_q <= 64'd1;
          pd_q <= 64'd1;
        end
      end
      StPowCk: k_q <= mag_e[rau_pkg::ExpW-1:0];
      StPowMl: if (k_q != '0) begin
        pn_q <= mul_wrap(pn_q, job_q.an[31:0]);
        pd_q <= mul_wrap(pd_q, job_q.ad[31:0]);
        k_q  <= k_q - {{(rau_pkg::ExpW-1){1'b0}}, 1'b1};
      end else begin
        num_q <= en_q[63] ? pd_q : pn_q;
        den_q <= en_q[63] ? pn_q : pd_q;
      end
      default: ;
    endcase
  end

  logic ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      busy_div_q  <= 1'b0;
      pow_phase_q <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      if (dv_start) busy_div_q <= 1'b1;
      else if (dv_done) busy_div_q <= 1'b0;
      unique case (st_q)
        StIdle: if (job_valid_i) begin
          ovf_q       <= 1'b0;
          pow_phase_q <= (job_i.kind == rau_pkg::KindPow);
          unique case (job_i.kind)
            rau_pkg::KindCross: st_q <= StMul;
            rau_pkg::KindPow:   st_q <= StRedSt;
            default:            st_q <= StOut;
          endcase
        end
        StMul:   st_q <= StComb;
        StComb:  st_q <= StRedSt;
        StRedSt: st_q <= (num_q == '0 || den_q == '0) ? StNorm : StGcd;
        StGcd:   if (v_q == '0) st_q <= StDivN;
        StDivN:  if (dv_done) st_q <= StDivD;
        StDivD:  if (dv_done) st_q <= StNorm;
        StNorm:  st_q <= pow_phase_q ? StPowCk : StOut;
        StPowCk: begin
          pow_phase_q <= 1'b0;
          if (den_q != 64'd1) begin
            st_q <= StOut;
          end else if (mag_e > 64'(rau_pkg::MaxExponent)) begin
            ovf_q <= 1'b1;
            st_q  <= StOut;
          end else begin
            st_q <= StPowMl;
          end
        end
        StPowMl: if (k_q == '0) st_q <= StRedSt;
        StOut:   if (rsp_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  // bad exponent gives 1/0 regardless of the reduced exponent value
  logic pow_bad_q;
  logic pow_bad;
  assign pow_bad = (st_q == StOut) && (ovf_q || pow_bad_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pow_bad_q <= 1'b0;
    else if (st_q == StIdle) pow_bad_q <= 1'b0;
    else if (st_q == StPowCk && (den_q != 64'd1 || mag_e > 64'(rau_pkg::MaxExponent)))
      pow_bad_q <= 1'b1;
  end

  assign rsp_valid_o        = (st_q == StOut);
  assign rsp_o.res_num      = pow_bad ? 64'sd1 : num_q;
  assign rsp_o.res_den      = pow_bad ? '0 : den_q[62:0];
  assign rsp_o.bad_result   = pow_bad || (den_q == '0);
  assign rsp_o.exp_overflow = ovf_q;

endmodule
`default_nettype wire

### test/rational_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
module rational_arithmetic_unit_tb;

  localparam logic [2:0] OpSpare5 = 3'd5;
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;
  localparam int unsigned NumRandom = 1580;
  localparam int unsigned IdleLimit = 80000;
  localparam int unsigned LongHold = 2000;
  localparam logic signed [31:0] IntMin = 32'sh8000_0000;
  localparam logic signed [31:0] IntMax = 32'sh7fff_ffff;

  typedef struct {
    rau_pkg::req_t q;
    bit            typed;
    rau_pkg::rsp_t e;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  rau_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rau_pkg::rsp_t rsp_o;

  stim_t stim_q[$];
  rau_pkg::rsp_t fraction_q[$];
  int unsigned n_fail = 0;
  int unsigned n_rsp = 0;
  int unsigned idle_cycles = 0;
  bit sending_done = 1'b0;

  rational_arithmetic_unit dut (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] mag64(logic [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    t = mag64(a) / mag64(b);
    return (a[63] != b[63]) ? 64'd0 - t : t;
  endfunction

  function automatic logic [63:0] rem_trunc(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    t = mag64(a) % mag64(b);
    return a[63] ? 64'd0 - t : t;
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] u, logic [63:0] v);
    logic [63:0] t;
    if (u == 0 || v == 0) return 64'd1;
    while (v != 0) begin
      t = rem_trunc(u, v);
      u = v;
      v = t;
    end
    return u;
  endfunction

  function automatic void reduce_frac(inout logic [63:0] n, inout logic [63:0] d);
    logic [63:0] g;
    g = gcd64(n, d);
    n = div_trunc(n, g);
    d = div_trunc(d, g);
    if (d[63]) begin
      n = 64'd0 - n;
      d = 64'd0 - d;
    end
    if (n == 0) d = 64'd1;
    if (d == 0) n = 64'd1;
    if (d == 64'h8000_0000_0000_0000) begin
      n = 64'd1;
      d = 64'd0;
    end
  endfunction

  function automatic rau_pkg::rsp_t mk_rsp(logic [63:0] n, logic [62:0] d, logic b, logic o);
    rau_pkg::rsp_t r;
    r.res_num = n;
    r.res_den = d;
    r.bad_result = b;
    r.exp_overflow = o;
    return r;
  endfunction

  function automatic rau_pkg::rsp_t predict_fraction(rau_pkg::req_t q);
    logic [63:0] an, ad, bn, bd, num, den, en, ed, pn, pd, k;
    logic ovf;
    an = {{32{q.a_num[31]}}, q.a_num};
    ad = {{32{q.a_den[31]}}, q.a_den};
    bn = {{32{q.b_num[31]}}, q.b_num};
    bd = {{32{q.b_den[31]}}, q.b_den};
    num = 64'd1;
    den = 64'd0;
    ovf = 1'b0;
    if (ad == 0) begin
      num = an;
    end else if (bd == 0) begin
      num = bn;
    end else if (q.req_type == rau_pkg::OpAdd || q.req_type == rau_pkg::OpSub) begin
      num = (q.req_type == rau_pkg::OpAdd) ? an * bd + ad * bn : an * bd - ad * bn;
      den = ad * bd;
      reduce_frac(num, den);
    end else if (q.req_type == rau_pkg::OpMul) begin
      num = an * bn;
      den = ad * bd;
      reduce_frac(num, den);
    end else if (q.req_type == rau_pkg::OpDiv) begin
      num = an * bd;
      den = ad * bn;
      reduce_frac(num, den);
    end else if (q.req_type == rau_pkg::OpPow) begin
      en = bn;
      ed = bd;
      reduce_frac(en, ed);
      if (ed == 1) begin
        k = mag64(en);
        if (k > rau_pkg::MaxExponent) begin
          ovf = 1'b1;
        end else begin
          pn = 64'd1;
          pd = 64'd1;
          for (int i = 0; i < k; i++) begin
            pn = pn * an;
            pd = pd * ad;
          end
          num = en[63] ? pd : pn;
          den = en[63] ? pn : pd;
          reduce_frac(num, den);
        end
      end
    end
    return mk_rsp(num, den[62:0], den == 0, ovf);
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed($urandom_range(0, 40)) - 20;
      4, 5: return $urandom;
      6: return $urandom_range(0, 1) ? IntMin : IntMax;
      7: return 32'sd1 <<< $urandom_range(0, 31);
      8: return -(32'sd1 <<< $urandom_range(0, 30));
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_den();
    logic signed [31:0] v;
    if ($urandom_range(0, 29) == 0) return 32'sd0;
    v = rand_word();
    return (v == 0) ? 32'sd3 : v;
  endfunction

  task automatic add_row(logic [2:0] op, int an, int ad, int bn, int bd,
                         bit typed = 0, rau_pkg::rsp_t e = '0);
    stim_t s;
    s.q = '{req_type: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    s.typed = typed;
    s.e = e;
    stim_q.insert(stim_q.size(), s);
  endtask

  initial begin
    stim_t s;
    add_row(rau_pkg::OpAdd, 1, 2, 1, 3);
    add_row(rau_pkg::OpAdd, -5, 0, 3, 4, 1, mk_rsp(-64'sd5, 0, 1, 0));
    add_row(rau_pkg::OpMul, 3, 4, 7, 0, 1, mk_rsp(64'd7, 0, 1, 0));
    add_row(rau_pkg::OpSub, IntMin, IntMax, IntMax, IntMin);
    add_row(rau_pkg::OpMul, IntMax, 1, IntMax, 1);
    add_row(rau_pkg::OpMul, IntMin, -1, IntMin, -1);
    add_row(rau_pkg::OpDiv, 5, 7, 0, 3, 1, mk_rsp(64'd1, 0, 1, 0));
    add_row(rau_pkg::OpDiv, IntMin, 1, -1, 1);
    add_row(rau_pkg::OpDiv, -6, -4, 9, -12);
    add_row(rau_pkg::OpPow, 2, 3, 17, 1, 1, mk_rsp(64'd1, 0, 1, 1));
    add_row(rau_pkg::OpPow, 2, 3, -17, 1, 1, mk_rsp(64'd1, 0, 1, 1));
    add_row(rau_pkg::OpPow, 2, 3, 1, 2, 1, mk_rsp(64'd1, 0, 1, 0));
    add_row(rau_pkg::OpPow, 2, 3, 0, 5, 1, mk_rsp(64'd1, 1, 0, 0));
    add_row(rau_pkg::OpPow, -2, 3, -6, 2);
    add_row(rau_pkg::OpPow, IntMax, IntMin, 16, 1);
    add_row(rau_pkg::OpPow, 0, 65536, 16, 1, 1, mk_rsp(64'd0, 1, 0, 0));
    add_row(rau_pkg::OpPow, 3, 65536, 4, 1, 1, mk_rsp(64'd1, 0, 1, 0));
    add_row(rau_pkg::OpPow, -7, 5, -16, -1);
    add_row(OpSpare5, 1, 2, 3, 4, 1, mk_rsp(64'd1, 0, 1, 0));
    add_row(OpSpare6, 1, 2, 3, 4, 1, mk_rsp(64'd1, 0, 1, 0));
    add_row(OpSpare7, 1, 2, 3, 4, 1, mk_rsp(64'd1, 0, 1, 0));
    add_row(rau_pkg::OpSub, 0, 5, 0, -9);
    for (int i = 0; i < NumRandom; i++) begin
      s.typed = 0;
      s.e = '0;
      s.q.req_type = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
      s.q.a_num = rand_word();
      s.q.a_den = rand_den();
      if (s.q.req_type == rau_pkg::OpPow && $urandom_range(0, 3) != 0) begin
        s.q.b_num = $signed($urandom_range(0, 40)) - 20;
        case ($urandom_range(0, 5))
          0: s.q.b_den = 2;
          1: s.q.b_den = -1;
          2: s.q.b_den = rand_den();
          default: s.q.b_den = 1;
        endcase
      end else begin
        s.q.b_num = rand_word();
        s.q.b_den = rand_den();
      end
      stim_q.insert(stim_q.size(), s);
    end
  end

  // sender: bursts with gaps, one pause until everything has drained
  initial begin
    int unsigned burst, idx, gap;
    bit paused;
    idx = 0;
    paused = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && idx < stim_q.size()) begin
        req_valid_i <= 1'b1;
        req_i <= stim_q[idx].q;
        do @(negedge clk_i); while (!req_ready_o);
        @(posedge clk_i);
        idx++;
        burst--;
      end
      if (!paused && idx >= 900) begin
        paused = 1'b1;
        req_valid_i <= 1'b0;
        @(posedge clk_i);
        while (fraction_q.size() != 0) @(posedge clk_i);
      end else begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          req_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    req_valid_i <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver: random stalls, runs of full readiness, one long hold-off
  initial begin
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && n_rsp >= 120) begin
        held = 1;
        rsp_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_ready_i <= 1'b1;
        repeat ($urandom_range(20, 200)) @(posedge clk_i);
      end else begin
        rsp_ready_i <= $urandom_range(0, 2) != 0;
        @(posedge clk_i);
      end
    end
  end

  int unsigned push_idx = 0;

  always @(posedge clk_i) begin
    rau_pkg::rsp_t e;
    if (req_valid_i && req_ready_o) begin
      fraction_q.insert(fraction_q.size(),
                        stim_q[push_idx].typed ? stim_q[push_idx].e
                                               : predict_fraction(stim_q[push_idx].q));
      push_idx++;
    end
    if (rsp_valid_o && rsp_ready_i) begin
      n_rsp++;
      if (fraction_q.size() == 0) begin
        $display("%0t: response with no request waiting: %p", $time, rsp_o);
        n_fail++;
      end else begin
        e = fraction_q.pop_front();
        if (rsp_o.res_num !== e.res_num) begin
          $display("%0t: res_num expected %0d actual %0d", $time, e.res_num, rsp_o.res_num);
          n_fail++;
        end
        if (rsp_o.res_den !== e.res_den) begin
          $display("%0t: res_den expected %0d actual %0d", $time, e.res_den, rsp_o.res_den);
          n_fail++;
        end
        if (rsp_o.bad_result !== e.bad_result) begin
          $display("%0t: bad_result expected %b actual %b", $time, e.bad_result,
                   rsp_o.bad_result);
          n_fail++;
        end
        if (rsp_o.exp_overflow !== e.exp_overflow) begin
          $display("%0t: exp_overflow expected %b actual %b", $time, e.exp_overflow,
                   rsp_o.exp_overflow);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("rational_arithmetic_unit verification failed");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    @(posedge clk_i);
    while (fraction_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_fail == 0 && fraction_q.size() == 0) begin
      $display("rational_arithmetic_unit verification clean");
    end else begin
      $display("rational_arithmetic_unit verification failed");
    end
    $finish;
  end

endmodule
